// File: sv/sibc_pkg.sv
`timescale 1ns / 1ps
package sibc_pkg;

    localparam int CB = 21;
    localparam int FB = 10;
    localparam int VW = 63;
    localparam int DW = 64;
    localparam int RW = 20;
    localparam int PW = 22;
    localparam int CORNERS = 8;

    localparam logic [PW-1:0] PEN_MAX = '1;
    localparam longint CMAXL = (longint'(1) <<< (CB - 1)) - 1;
    localparam longint CMINL = -(longint'(1) <<< (CB - 1));

    localparam logic [VW-1:0] AXIS_X_RST = VW'(64'd1 << (FB + 2 * CB));
    localparam logic [VW-1:0] AXIS_Y_RST = VW'(64'd1 << (FB + CB));
    localparam logic [VW-1:0] AXIS_Z_RST = VW'(64'd1 << FB);
    localparam logic [VW-1:0] HALF_RST   = AXIS_X_RST | AXIS_Y_RST | AXIS_Z_RST;

    localparam logic [2:0] REG_CENTER = 3'd0;
    localparam logic [2:0] REG_AXIS_X = 3'd1;
    localparam logic [2:0] REG_AXIS_Y = 3'd2;
    localparam logic [2:0] REG_AXIS_Z = 3'd3;
    localparam logic [2:0] REG_HALF   = 3'd4;

    typedef logic signed [CB-1:0] t_comp;
    typedef t_comp t_vec [3];
    typedef logic signed [DW-1:0] t_depth;

    typedef enum logic [1:0] {
        CMD_SPHERE  = 2'd0,
        CMD_SEGMENT = 2'd1,
        CMD_BOX     = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [VW-1:0] center;
        logic [VW-1:0] axis_x;
        logic [VW-1:0] axis_y;
        logic [VW-1:0] axis_z;
        logic [VW-1:0] half;
    } t_box_cfg;

    typedef struct packed {
        logic          hit;
        t_depth        depth;
        logic [VW-1:0] nrm;
        logic [VW-1:0] cp;
    } t_sres;

    typedef struct packed {
        logic       vld;
        logic [1:0] sel;
        logic       neg;
        t_depth     val;
    } t_cand;

    function automatic t_vec f_unpack(input logic [VW-1:0] p);
        t_vec v;
        for (int k = 0; k < 3; k++) begin
            v[k] = t_comp'(p[(2 - k) * CB +: CB]);
        end
        return v;
    endfunction

    function automatic logic [VW-1:0] f_pack(input t_vec v);
        logic [VW-1:0] r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            r[(2 - k) * CB +: CB] = v[k];
        end
        return r;
    endfunction

    function automatic t_comp f_sat(input t_depth x);
        if (x > CMAXL) begin
            return t_comp'(CMAXL);
        end
        if (x < CMINL) begin
            return t_comp'(CMINL);
        end
        return t_comp'(x);
    endfunction

    function automatic t_comp f_neg(input t_comp a);
        return (a == t_comp'(CMINL)) ? t_comp'(CMAXL) : t_comp'(-a);
    endfunction

    function automatic t_vec f_axis(input t_box_cfg cfg, input logic [1:0] sel);
        t_vec v;
        unique case (sel)
            2'd0:    v = f_unpack(cfg.axis_x);
            2'd1:    v = f_unpack(cfg.axis_y);
            default: v = f_unpack(cfg.axis_z);
        endcase
        return v;
    endfunction

    // Later candidate wins only when strictly deeper, so earlier corners keep ties.
    function automatic t_cand f_merge(input t_cand l, input t_cand r);
        if (r.vld && (!l.vld || $signed(r.val) > $signed(l.val))) begin
            return r;
        end
        return l;
    endfunction

endpackage

// File: sv/shape_in_box_containment.sv
`timescale 1ns / 1ps
// Oriented box containment test with a push-back manifold for each item.
// Input channel s_axis: tuser carries the command (sphere, segment, inner box),
// tdata carries the shape: both points, the radius and the inner box frame.
// Output channel m_axis: tuser is the hit flag, tdata holds push normal,
// penetration and contact point; all three are zero when there is no hit.
// The container (centre, three unit axes, half extents) is written through the
// APB port; registers lie at byte address 8*i. The user must write it only while
// no item is in flight; the block itself does not enforce this. Items pass through
// five stages of transform, multiply, margin, corner products and candidate
// selection in the sphere and corner units, and one output register. One item is
// accepted each cycle unless the output is stalled by m_axis_tready.
// When the receiver holds m_axis_tready low with a result waiting, every stage
// holds, empty ones included, and s_axis_tready drops until the result is taken.
// Reset clears all valid bits and loads the container with centre zero, the
// unit x, y and z axes and half extents of one.
module shape_in_box_containment
    import sibc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_a, point_b, shape_radius, inner_axis_x, inner_axis_y,
    // inner_axis_z, inner_half_extents, zero pad
    input  logic [399:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // push_normal, penetration, contact_point, zero pad
    output logic [151:0] m_axis_tdata,
    // hit
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int OFS_PB  = VW;
    localparam int OFS_RAD = 2 * VW;
    localparam int OFS_IX  = OFS_RAD + RW;
    localparam int OFS_IY  = OFS_IX + VW;
    localparam int OFS_IZ  = OFS_IY + VW;
    localparam int OFS_IHE = OFS_IZ + VW;

    t_box_cfg      r_cfg;
    logic          en;
    logic [4:0]    r_vld;
    t_cmd          r_cmd [5];
    t_sres         sres_a, sres_b, m;
    t_cand         box_cand [4];
    t_cand         best;
    logic [VW-1:0] box_ic;
    t_vec          bax, bn;
    t_depth        q;
    logic [PW-1:0] n_pen;
    logic          r_out_vld, r_hit;
    logic [VW-1:0] r_nrm, r_cp;
    logic [PW-1:0] r_pen;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign pready        = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center <= '0;
            r_cfg.axis_x <= AXIS_X_RST;
            r_cfg.axis_y <= AXIS_Y_RST;
            r_cfg.axis_z <= AXIS_Z_RST;
            r_cfg.half   <= HALF_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[5:3])
                REG_CENTER: r_cfg.center <= pwdata[VW-1:0];
                REG_AXIS_X: r_cfg.axis_x <= pwdata[VW-1:0];
                REG_AXIS_Y: r_cfg.axis_y <= pwdata[VW-1:0];
                REG_AXIS_Z: r_cfg.axis_z <= pwdata[VW-1:0];
                REG_HALF:   r_cfg.half   <= pwdata[VW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_CENTER: prdata = {1'b0, r_cfg.center};
            REG_AXIS_X: prdata = {1'b0, r_cfg.axis_x};
            REG_AXIS_Y: prdata = {1'b0, r_cfg.axis_y};
            REG_AXIS_Z: prdata = {1'b0, r_cfg.axis_z};
            REG_HALF:   prdata = {1'b0, r_cfg.half};
            default:    prdata = '0;
        endcase
    end

    sibc_sphere u_sphere_a (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_point  (s_axis_tdata[VW-1:0]),
        .i_radius (s_axis_tdata[OFS_RAD +: RW]),
        .o_res    (sres_a)
    );

    sibc_sphere u_sphere_b (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_point  (s_axis_tdata[OFS_PB +: VW]),
        .i_radius (s_axis_tdata[OFS_RAD +: RW]),
        .o_res    (sres_b)
    );

    sibc_box u_box (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_center (s_axis_tdata[VW-1:0]),
        .i_iax_x  (s_axis_tdata[OFS_IX +: VW]),
        .i_iax_y  (s_axis_tdata[OFS_IY +: VW]),
        .i_iax_z  (s_axis_tdata[OFS_IZ +: VW]),
        .i_ihe    (s_axis_tdata[OFS_IHE +: VW]),
        .o_cand   (box_cand),
        .o_ic     (box_ic)
    );

    always_comb begin
        best = f_merge(f_merge(box_cand[0], box_cand[1]),
                       f_merge(box_cand[2], box_cand[3]));
        bax  = f_axis(r_cfg, best.sel);
        for (int i = 0; i < 3; i++) begin
            bn[i] = best.neg ? f_neg(bax[i]) : bax[i];
        end
        unique case (r_cmd[4])
            CMD_SPHERE: m = sres_a;
            CMD_SEGMENT: begin
                if (sres_a.hit && (!sres_b.hit
                    || $signed(sres_a.depth) >= $signed(sres_b.depth))) begin
                    m = sres_a;
                end else begin
                    m = sres_b;
                end
            end
            CMD_BOX: begin
                m.hit   = best.vld;
                m.depth = best.val;
                m.nrm   = f_pack(bn);
                m.cp    = box_ic;
                if (!best.vld) begin
                    m = '0;
                end
            end
            CMD_NONE: m = '0;
        endcase
        q = $signed(m.depth) >>> FB;
        if (!m.hit || $signed(m.depth) <= 0) begin
            n_pen = '0;
        end else if (q > DW'(PEN_MAX)) begin
            n_pen = PEN_MAX;
        end else begin
            n_pen = q[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[3:0], s_axis_tvalid};
            r_out_vld <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[0] <= t_cmd'(s_axis_tuser);
            for (int s = 1; s < 5; s++) begin
                r_cmd[s] <= r_cmd[s-1];
            end
            r_hit <= m.hit;
            r_nrm <= m.hit ? m.nrm : '0;
            r_cp  <= m.hit ? m.cp : '0;
            r_pen <= n_pen;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {4'b0, r_cp, r_pen, r_nrm};

`ifndef NO_ASSERTIONS
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("result without hit carries nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(r_vld) && m_axis_tvalid))
        else $error("pipeline moved while the output was stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && r_vld == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

// File: sv/sibc_sphere.sv
`timescale 1ns / 1ps
module sibc_sphere
    import sibc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  t_box_cfg      i_cfg,
    input  logic [VW-1:0] i_point,
    input  logic [RW-1:0] i_radius,
    output t_sres         o_res
);

    localparam int PRW = 2 * CB + 1;
    localparam int LW  = PRW + 2;
    localparam int MW  = LW + 2;

    t_vec cen, he, pt, ax_sel3, ax_sel4;
    t_vec ax [3];
    logic signed [CB:0]      diff [3];
    logic signed [PRW-1:0]   n_prod [3][3];
    logic signed [PRW-1:0]   r_prod [3][3];
    logic [RW-1:0]           r_rad1, r_rad2;
    logic signed [LW-1:0]    loc [3];
    logic signed [MW-1:0]    n_marg [3];
    logic signed [MW-1:0]    r_marg [3];
    logic [2:0]              n_pos, r_pos;
    logic signed [MW-1:0]    r20, mn;
    logic [1:0]              n_sel, r_sel3, r_sel4;
    logic                    n_hit, r_hit3, r_hit4;
    logic                    n_neg, r_neg3, r_neg4;
    t_depth                  n_dep, r_dep3, r_dep4;
    logic signed [2*CB-1:0]  n_cprod [3];
    logic signed [2*CB-1:0]  r_cprod [3];
    logic signed [PRW-1:0]   sp [3];
    t_vec                    cp, nrm;
    t_sres                   n_res, r_res;

    always_comb begin
        cen = f_unpack(i_cfg.center);
        he  = f_unpack(i_cfg.half);
        pt  = f_unpack(i_point);
        for (int k = 0; k < 3; k++) begin
            ax[k] = f_axis(i_cfg, 2'(k));
        end
        ax_sel3 = f_axis(i_cfg, r_sel3);
        ax_sel4 = f_axis(i_cfg, r_sel4);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = (CB + 1)'(pt[i]) - (CB + 1)'(cen[i]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n_prod[k][i] = PRW'(diff[i]) * PRW'(ax[k][i]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            loc[k] = LW'(r_prod[k][0]) + LW'(r_prod[k][1]) + LW'(r_prod[k][2]);
            n_pos[k] = !loc[k][LW-1];
            n_marg[k] = (MW'(he[k]) <<< FB)
                      - (loc[k][LW-1] ? -MW'(loc[k]) : MW'(loc[k]));
        end
    end

    always_comb begin
        r20   = MW'({r_rad2, {FB{1'b0}}});
        n_hit = (r_marg[0] < r20) || (r_marg[1] < r20) || (r_marg[2] < r20);
        n_sel = 2'd0;
        mn    = r_marg[0];
        if (r_marg[1] < mn) begin
            n_sel = 2'd1;
            mn    = r_marg[1];
        end
        if (r_marg[2] < mn) begin
            n_sel = 2'd2;
            mn    = r_marg[2];
        end
        n_dep = DW'(r20) - DW'(mn);
        n_neg = r_pos[n_sel];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cprod[i] = (2 * CB)'(ax_sel3[i]) * (2 * CB)'(he[r_sel3]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp[i]  = r_neg4 ? PRW'(r_cprod[i]) : -PRW'(r_cprod[i]);
            cp[i]  = f_sat(DW'(cen[i]) + DW'(sp[i] >>> FB));
            nrm[i] = r_neg4 ? f_neg(ax_sel4[i]) : ax_sel4[i];
        end
        n_res.hit   = r_hit4;
        n_res.depth = r_hit4 ? r_dep4 : '0;
        n_res.nrm   = r_hit4 ? f_pack(nrm) : '0;
        n_res.cp    = r_hit4 ? f_pack(cp) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_rad1  <= i_radius;
            r_marg  <= n_marg;
            r_pos   <= n_pos;
            r_rad2  <= r_rad1;
            r_hit3  <= n_hit;
            r_sel3  <= n_sel;
            r_neg3  <= n_neg;
            r_dep3  <= n_dep;
            r_cprod <= n_cprod;
            r_hit4  <= r_hit3;
            r_sel4  <= r_sel3;
            r_neg4  <= r_neg3;
            r_dep4  <= r_dep3;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/sibc_box.sv
`timescale 1ns / 1ps
module sibc_box
    import sibc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  t_box_cfg      i_cfg,
    input  logic [VW-1:0] i_center,
    input  logic [VW-1:0] i_iax_x,
    input  logic [VW-1:0] i_iax_y,
    input  logic [VW-1:0] i_iax_z,
    input  logic [VW-1:0] i_ihe,
    output t_cand         o_cand [4],
    output logic [VW-1:0] o_ic
);

    localparam int BPW = 2 * CB;
    localparam int SW  = BPW + 3;
    localparam int CRW = SW - FB;
    localparam int DFW = CRW + 1;
    localparam int PRW = DFW + CB;
    localparam int LW  = PRW + 2;

    t_vec iax [3];
    t_vec ax [3];
    t_vec ihe, cen, he, ic0;
    t_vec r_ic1, r_ic2, r_ic3, r_ic4, r_ic5;
    logic signed [BPW-1:0] n_bp [3][3];
    logic signed [BPW-1:0] r_bp [3][3];
    logic signed [SW-1:0]  acc [CORNERS][3];
    logic signed [DFW-1:0] n_diff [CORNERS][3];
    logic signed [DFW-1:0] r_diff [CORNERS][3];
    logic signed [PRW-1:0] n_cp [CORNERS][3][3];
    logic signed [PRW-1:0] r_cp [CORNERS][3][3];
    logic signed [LW-1:0]  loc [CORNERS][3];
    t_depth                n_p [CORNERS][3];
    t_depth                r_p [CORNERS][3];
    logic [2:0]            n_pos [CORNERS];
    logic [2:0]            r_pos [CORNERS];
    t_cand                 cand [CORNERS];
    t_cand                 n_cand [4];
    t_cand                 r_cand [4];

    always_comb begin
        cen    = f_unpack(i_cfg.center);
        he     = f_unpack(i_cfg.half);
        ic0    = f_unpack(i_center);
        ihe    = f_unpack(i_ihe);
        iax[0] = f_unpack(i_iax_x);
        iax[1] = f_unpack(i_iax_y);
        iax[2] = f_unpack(i_iax_z);
        for (int k = 0; k < 3; k++) begin
            ax[k] = f_axis(i_cfg, 2'(k));
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_bp[j][i] = BPW'(iax[j][i]) * BPW'(ihe[j]);
            end
        end
    end

    // Corner index bit 2 is the x sign, bit 1 the y sign, bit 0 the z sign (1 is plus).
    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            for (int i = 0; i < 3; i++) begin
                acc[c][i] = SW'(r_ic1[i]) <<< FB;
                for (int j = 0; j < 3; j++) begin
                    acc[c][i] = c[2 - j] ? acc[c][i] + SW'(r_bp[j][i])
                                         : acc[c][i] - SW'(r_bp[j][i]);
                end
                n_diff[c][i] = DFW'(acc[c][i] >>> FB) - DFW'(cen[i]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    n_cp[c][k][i] = PRW'(r_diff[c][i]) * PRW'(ax[k][i]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            for (int k = 0; k < 3; k++) begin
                loc[c][k] = LW'(r_cp[c][k][0]) + LW'(r_cp[c][k][1]) + LW'(r_cp[c][k][2]);
                n_pos[c][k] = !loc[c][k][LW-1];
                n_p[c][k] = (loc[c][k][LW-1] ? -DW'(loc[c][k]) : DW'(loc[c][k]))
                          - (DW'(he[k]) <<< FB);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            cand[c].vld = (r_p[c][0] > 0) || (r_p[c][1] > 0) || (r_p[c][2] > 0);
            if (r_p[c][0] >= r_p[c][1] && r_p[c][0] >= r_p[c][2]) begin
                cand[c].sel = 2'd0;
            end else if (r_p[c][1] >= r_p[c][0] && r_p[c][1] >= r_p[c][2]) begin
                cand[c].sel = 2'd1;
            end else begin
                cand[c].sel = 2'd2;
            end
            cand[c].val = r_p[c][cand[c].sel];
            cand[c].neg = r_pos[c][cand[c].sel];
        end
        for (int m = 0; m < 4; m++) begin
            n_cand[m] = f_merge(cand[2 * m], cand[2 * m + 1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bp   <= n_bp;
            r_ic1  <= ic0;
            r_diff <= n_diff;
            r_ic2  <= r_ic1;
            r_cp   <= n_cp;
            r_ic3  <= r_ic2;
            r_p    <= n_p;
            r_pos  <= n_pos;
            r_ic4  <= r_ic3;
            r_cand <= n_cand;
            r_ic5  <= r_ic4;
        end
    end

    assign o_cand = r_cand;
    assign o_ic   = f_pack(r_ic5);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sibc_pkg::*;

    localparam longint U = 1024;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_cmd        cmd;
        logic [62:0] pa;
        logic [62:0] pb;
        logic [19:0] rad;
        logic [62:0] ix;
        logic [62:0] iy;
        logic [62:0] iz;
        logic [62:0] ih;
    } shape_t;

    typedef struct packed {
        logic        hit;
        logic [62:0] nrm;
        logic [21:0] pen;
        logic [62:0] cp;
    } manifold_t;

    typedef struct {
        bit     hit;
        longint depth;
        longint n[3];
        longint c[3];
    } contact_t;

    typedef struct {
        shape_t    s;
        bit        fixed;
        manifold_t want;
    } row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [399:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    shape_in_box_containment dut (.*);

    logic [62:0] cfg_regs [5];
    longint      box_cen [3];
    longint      box_ax [3][3];
    longint      box_he [3];
    manifold_t   expected_q [$];
    int          err_count;
    int          cycle_count;
    int          burst_left;
    row_t        rows [$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint comp(logic [62:0] p, int k);
        return longint'(t_comp'(p[(2 - k) * CB +: CB]));
    endfunction

    function automatic longint clamp_c(longint v);
        return v > CMAXL ? CMAXL : (v < CMINL ? CMINL : v);
    endfunction

    function automatic logic [62:0] pack3(longint v0, longint v1, longint v2);
        logic [62:0] r;
        longint      t [3];
        longint      q;
        t[0] = v0;
        t[1] = v1;
        t[2] = v2;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            q = clamp_c(t[k]);
            r[(2 - k) * CB +: CB] = q[CB-1:0];
        end
        return r;
    endfunction

    function automatic logic [62:0] vec(longint x, longint y, longint z);
        logic [62:0] r;
        r = '0;
        r[2*CB +: CB] = x[CB-1:0];
        r[CB +: CB]   = y[CB-1:0];
        r[0 +: CB]    = z[CB-1:0];
        return r;
    endfunction

    function automatic void load_container();
        for (int k = 0; k < 3; k++) begin
            box_cen[k]   = comp(cfg_regs[REG_CENTER], k);
            box_ax[0][k] = comp(cfg_regs[REG_AXIS_X], k);
            box_ax[1][k] = comp(cfg_regs[REG_AXIS_Y], k);
            box_ax[2][k] = comp(cfg_regs[REG_AXIS_Z], k);
            box_he[k]    = comp(cfg_regs[REG_HALF], k);
        end
    endfunction

    function automatic longint local_coord(longint p0, longint p1, longint p2, int k);
        return (p0 - box_cen[0]) * box_ax[k][0] + (p1 - box_cen[1]) * box_ax[k][1]
             + (p2 - box_cen[2]) * box_ax[k][2];
    endfunction

    function automatic void flip_axis(ref contact_t m, input int sel, input bit neg);
        for (int i = 0; i < 3; i++) begin
            if (!neg) m.n[i] = box_ax[sel][i];
            else m.n[i] = (box_ax[sel][i] == CMINL) ? CMAXL : -box_ax[sel][i];
        end
    endfunction

    function automatic contact_t sphere_contact(logic [62:0] p, longint r20);
        contact_t m;
        longint   loc [3];
        longint   marg [3];
        longint   mn;
        longint   s;
        int       sel;
        m = '{default: 0};
        for (int k = 0; k < 3; k++) begin
            loc[k] = local_coord(comp(p, 0), comp(p, 1), comp(p, 2), k);
            marg[k] = box_he[k] * U - (loc[k] < 0 ? -loc[k] : loc[k]);
        end
        if (marg[0] >= r20 && marg[1] >= r20 && marg[2] >= r20) return m;
        sel = 0;
        mn = marg[0];
        if (marg[1] < mn) begin
            mn = marg[1];
            sel = 1;
        end
        if (marg[2] < mn) begin
            mn = marg[2];
            sel = 2;
        end
        m.hit = 1;
        m.depth = r20 - mn;
        flip_axis(m, sel, loc[sel] >= 0);
        s = loc[sel] >= 0 ? 1 : -1;
        for (int i = 0; i < 3; i++)
            m.c[i] = clamp_c(box_cen[i] + ((s * box_ax[sel][i] * box_he[sel]) >>> FB));
        return m;
    endfunction

    function automatic contact_t box_contact(shape_t it);
        contact_t m;
        longint   crn [3];
        longint   loc [3];
        longint   ov [3];
        longint   worst;
        int       sel;
        int       best;
        bit       neg;
        int       sg [3];
        m = '{default: 0};
        worst = 0;
        best = -1;
        neg = 0;
        for (int c = 0; c < 8; c++) begin
            sg[0] = c[2] ? 1 : -1;
            sg[1] = c[1] ? 1 : -1;
            sg[2] = c[0] ? 1 : -1;
            for (int i = 0; i < 3; i++)
                crn[i] = (comp(it.pa, i) * U + sg[0] * comp(it.ix, i) * comp(it.ih, 0)
                        + sg[1] * comp(it.iy, i) * comp(it.ih, 1)
                        + sg[2] * comp(it.iz, i) * comp(it.ih, 2)) >>> FB;
            for (int k = 0; k < 3; k++) begin
                loc[k] = local_coord(crn[0], crn[1], crn[2], k);
                ov[k] = (loc[k] < 0 ? -loc[k] : loc[k]) - box_he[k] * U;
            end
            if (ov[0] > 0 || ov[1] > 0 || ov[2] > 0) begin
                if (ov[0] >= ov[1] && ov[0] >= ov[2]) sel = 0;
                else if (ov[1] >= ov[0] && ov[1] >= ov[2]) sel = 1;
                else sel = 2;
                if (ov[sel] > worst) begin
                    worst = ov[sel];
                    best = sel;
                    neg = loc[sel] >= 0;
                end
            end
        end
        if (best < 0) return m;
        m.hit = 1;
        m.depth = worst;
        flip_axis(m, best, neg);
        for (int i = 0; i < 3; i++) m.c[i] = comp(it.pa, i);
        return m;
    endfunction

    function automatic manifold_t predict_manifold(shape_t it);
        contact_t  m;
        contact_t  mb;
        manifold_t r;
        longint    r20;
        longint    pen;
        r20 = longint'(it.rad) * U;
        m = '{default: 0};
        case (it.cmd)
            CMD_SPHERE: m = sphere_contact(it.pa, r20);
            CMD_SEGMENT: begin
                m = sphere_contact(it.pa, r20);
                mb = sphere_contact(it.pb, r20);
                if (!(m.hit && (!mb.hit || m.depth >= mb.depth)) && mb.hit) m = mb;
            end
            CMD_BOX: m = box_contact(it);
            default: m.hit = 0;
        endcase
        r = '0;
        if (m.hit) begin
            pen = m.depth / U;
            if (pen > 4194303) pen = 4194303;
            if (pen < 0) pen = 0;
            r.hit = 1'b1;
            r.nrm = pack3(m.n[0], m.n[1], m.n[2]);
            r.pen = pen[21:0];
            r.cp = pack3(m.c[0], m.c[1], m.c[2]);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        manifold_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", {63'd0, m_axis_tuser}, 64'd0);
            end else begin
                w = expected_q.pop_front();
                if (m_axis_tuser !== w.hit) report_mismatch("hit", m_axis_tuser, w.hit);
                if (m_axis_tdata[62:0] !== w.nrm)
                    report_mismatch("push_normal", m_axis_tdata[62:0], w.nrm);
                if (m_axis_tdata[84:63] !== w.pen)
                    report_mismatch("penetration", m_axis_tdata[84:63], w.pen);
                if (m_axis_tdata[147:85] !== w.cp)
                    report_mismatch("contact_point", m_axis_tdata[147:85], w.cp);
            end
        end
    end

    always @(negedge i_clk) begin
        int phase;
        phase = (cycle_count / 97) % 4;
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (phase == 0) m_axis_tready <= 1'b1;
        else if (phase == 1) m_axis_tready <= $urandom_range(0, 1);
        else if (phase == 2) m_axis_tready <= ($urandom_range(0, 7) != 0);
        else m_axis_tready <= ($urandom_range(0, 5) == 0);
    end

    task automatic send_item(shape_t it, bit fixed, manifold_t want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {2'b00, it.ih, it.iz, it.iy, it.ix, it.rad, it.pb, it.pa};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(fixed ? want : predict_manifold(it));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_regs[idx] = value[62:0];
        load_container();
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic longint rnd_c(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [62:0] rnd_field();
        return {$urandom(), $urandom()} >> 1;
    endfunction

    function automatic longint unit_c();
        case ($urandom_range(0, 4))
            0: return U;
            1: return -U;
            2: return 724;
            3: return -724;
            default: return 0;
        endcase
    endfunction

    function automatic shape_t rnd_shape(longint span);
        shape_t it;
        int     pick;
        pick = $urandom_range(0, 19);
        it.cmd = pick == 0 ? CMD_NONE : t_cmd'(pick % 3);
        it.pa = vec(rnd_c(span), rnd_c(span), rnd_c(span));
        it.pb = vec(rnd_c(span), rnd_c(span), rnd_c(span));
        it.rad = $urandom_range(0, 4 * U);
        it.ix = vec(unit_c(), unit_c(), unit_c());
        it.iy = vec(unit_c(), unit_c(), unit_c());
        it.iz = vec(unit_c(), unit_c(), unit_c());
        it.ih = vec($urandom_range(0, 4 * U), $urandom_range(0, 4 * U), $urandom_range(0, 4 * U));
        if ($urandom_range(0, 9) == 0) begin
            it.pa = rnd_field();
            it.pb = rnd_field();
            it.rad = $urandom();
            it.ix = rnd_field();
            it.iy = rnd_field();
            it.iz = rnd_field();
            it.ih = rnd_field();
        end
        return it;
    endfunction

    function automatic shape_t mk(t_cmd c, logic [62:0] pa, logic [62:0] pb, logic [19:0] r,
                                  logic [62:0] ih);
        shape_t it;
        it.cmd = c;
        it.pa = pa;
        it.pb = pb;
        it.rad = r;
        it.ix = vec(U, 0, 0);
        it.iy = vec(0, U, 0);
        it.iz = vec(0, 0, U);
        it.ih = ih;
        return it;
    endfunction

    task automatic random_run(int count, longint span, bit pause);
        for (int n = 0; n < count; n++) begin
            if (pause && n == count / 2) drain();
            send_item(rnd_shape(span), 0, '0);
        end
    endtask

    task automatic write_container(logic [62:0] c, logic [62:0] x, logic [62:0] y,
                                   logic [62:0] z, logic [62:0] h);
        drain();
        write_reg(REG_CENTER, {1'b1, c});
        write_reg(REG_AXIS_X, {1'b0, x});
        write_reg(REG_AXIS_Y, {1'b1, y});
        write_reg(REG_AXIS_Z, {1'b0, z});
        write_reg(REG_HALF, {1'b0, h});
    endtask

    initial begin
        shape_t    it;
        manifold_t zero;
        zero = '0;
        err_count = 0;
        cycle_count = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_SPHERE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_regs[REG_CENTER] = '0;
        cfg_regs[REG_AXIS_X] = AXIS_X_RST;
        cfg_regs[REG_AXIS_Y] = AXIS_Y_RST;
        cfg_regs[REG_AXIS_Z] = AXIS_Z_RST;
        cfg_regs[REG_HALF] = HALF_RST;
        load_container();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{mk(CMD_SPHERE, '0, '0, '0, '0), 1, zero});
        it = mk(CMD_NONE, '1, '1, '1, '1);
        rows.push_back('{it, 1, zero});
        rows.push_back('{mk(CMD_SPHERE, vec(2 * U, 0, 0), '0, 0, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, vec(0, -2 * U, 0), '0, 0, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, vec(U, U, 0), '0, 0, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, vec(U, U, U), '0, 0, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, '0, '0, 20'hFFFFF, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, vec(CMAXL, CMINL, CMAXL), '0, 20'hFFFFF, '0), 0, zero});
        rows.push_back('{mk(CMD_SPHERE, '1, '0, 1, '0), 0, zero});
        rows.push_back('{mk(CMD_SEGMENT, vec(0, 0, 0), vec(0, 0, 0), U / 2, '0), 1, zero});
        rows.push_back('{mk(CMD_SEGMENT, vec(2 * U, 0, 0), vec(-2 * U, 0, 0), 0, '0), 0, zero});
        rows.push_back('{mk(CMD_SEGMENT, vec(0, 0, 0), vec(0, 0, 3 * U), U, '0), 0, zero});
        rows.push_back('{mk(CMD_SEGMENT, '1, '0, 20'hFFFFF, '1), 0, zero});
        rows.push_back('{mk(CMD_BOX, '0, '0, 0, vec(U / 2, U / 2, U / 2)), 1, zero});
        rows.push_back('{mk(CMD_BOX, '0, '0, 0, vec(2 * U, U / 2, U / 2)), 0, zero});
        rows.push_back('{mk(CMD_BOX, vec(U, U, U), '0, 0, vec(U, U, U)), 0, zero});
        rows.push_back('{mk(CMD_BOX, '0, '0, 0, vec(-3 * U, U, -U)), 0, zero});
        rows.push_back('{mk(CMD_BOX, '1, '1, '1, '1), 0, zero});
        it = mk(CMD_BOX, vec(CMAXL, CMINL, 0), '0, 0, vec(CMAXL, CMAXL, CMAXL));
        it.ix = vec(CMINL, CMAXL, CMINL);
        rows.push_back('{it, 0, zero});
        foreach (rows[i]) send_item(rows[i].s, rows[i].fixed, rows[i].want);

        random_run(250, 3 * U, 1);

        write_container(vec(U / 2, -U, 3 * U), vec(1023, 0, 0), vec(0, 0, -U), vec(0, U, 0),
                        vec(U, 2 * U, 3 * U));
        send_item(mk(CMD_SPHERE, vec(U / 2 + 1025, -U, 3 * U), '0, 1, '0), 0, zero);
        random_run(220, 5 * U, 0);

        write_container(vec(rnd_c(U), rnd_c(U), rnd_c(U)), vec(724, 724, 0),
                        vec(-724, 724, 0), vec(0, 0, U), vec(3 * U, U / 4, 5 * U));
        random_run(220, 6 * U, 0);

        write_container(vec(CMAXL, CMINL, CMAXL), vec(CMINL, CMINL, CMINL),
                        vec(CMAXL, CMAXL, CMAXL), vec(CMINL, CMAXL, 0), vec(CMAXL, CMAXL, CMAXL));
        random_run(200, CMAXL, 0);

        write_container('0, '0, '0, '0, vec(-U, -2 * U, CMINL));
        random_run(120, 4 * U, 0);

        write_container('1, '1, '1, '1, '1);
        random_run(120, CMAXL, 0);

        write_container('0, AXIS_X_RST, AXIS_Y_RST, AXIS_Z_RST, vec(8 * U, 6 * U, 4 * U));
        random_run(200, 9 * U, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
